// ===== sv/sfb64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb64_pkg
// Shared types, constants and functions of the base64 serial frame encoder.
// ----------------------------------------------------------------------------
package sfb64_pkg;

    localparam int MAX_PACKET = 508;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0]  CH_PRE0  = 8'h06;
    localparam logic [7:0]  CH_PRE1  = 8'h09;
    localparam logic [7:0]  CH_PAD   = 8'h3D;
    localparam logic [7:0]  CH_NL    = 8'h0A;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        OP_START,
        OP_RAW,
        OP_END
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
    } op_word_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_START,
        FS_LHI,
        FS_LLO,
        FS_DATA,
        FS_END
    } front_state_t;

    typedef enum logic [1:0] {
        BK_OP,
        BK_LO,
        BK_PAD,
        BK_NL
    } back_state_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
        begin
            return w + 8'h41;
        end
        else if (v < 6'd52)
        begin
            return w + 8'd71;
        end
        else if (v < 6'd62)
        begin
            return w - 8'd4;
        end
        else if (v == 6'd62)
        begin
            return 8'h2B;
        end
        else
        begin
            return 8'h2F;
        end
    endfunction

endpackage

// ===== sv/sfb64_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb64_front
// Accepts packet bytes, tracks the open frame and issues start, raw and end stream operations.
// ----------------------------------------------------------------------------
module sfb64_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           data_byte,
    input  logic                 first,
    input  logic                 last,
    input  logic [8:0]           packet_length,
    output logic                 q_push,
    output sfb64_pkg::op_word_t  q_word,
    input  logic                 q_full
);

    sfb64_pkg::front_state_t state_reg, state_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;
    logic [15:0] flen_reg, flen_next;
    logic        in_frame_reg, in_frame_next;

    logic        adv;
    logic        done;
    logic        accept;
    logic [15:0] plen_ext;

    assign adv    = (state_reg != sfb64_pkg::FS_IDLE) && !q_full;
    assign done   = adv && ((state_reg == sfb64_pkg::FS_END) ||
                            ((state_reg == sfb64_pkg::FS_DATA) && !last_reg));
    assign full   = (state_reg != sfb64_pkg::FS_IDLE) && !done;
    assign accept = push && !full;

    always_comb
    begin
        plen_ext = {7'b0, packet_length};
        if (plen_ext > 16'(sfb64_pkg::MAX_PACKET))
        begin
            plen_ext = 16'(sfb64_pkg::MAX_PACKET);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (adv)
        begin
            case (state_reg)
                sfb64_pkg::FS_START: state_next = sfb64_pkg::FS_LHI;
                sfb64_pkg::FS_LHI:   state_next = sfb64_pkg::FS_LLO;
                sfb64_pkg::FS_LLO:   state_next = sfb64_pkg::FS_DATA;
                sfb64_pkg::FS_DATA:  state_next = last_reg ? sfb64_pkg::FS_END
                                                           : sfb64_pkg::FS_IDLE;
                sfb64_pkg::FS_END:   state_next = sfb64_pkg::FS_IDLE;
                default:             state_next = sfb64_pkg::FS_IDLE;
            endcase
        end
        if (accept)
        begin
            if (first)
            begin
                state_next = sfb64_pkg::FS_START;
            end
            else if (in_frame_reg)
            begin
                state_next = sfb64_pkg::FS_DATA;
            end
            else
            begin
                state_next = sfb64_pkg::FS_IDLE;
            end
        end
    end

    // outputs
    always_comb
    begin
        q_push = adv;
        q_word.kind = sfb64_pkg::OP_RAW;
        q_word.data = 8'h00;
        case (state_reg)
            sfb64_pkg::FS_START: q_word.kind = sfb64_pkg::OP_START;
            sfb64_pkg::FS_LHI:   q_word.data = flen_reg[15:8];
            sfb64_pkg::FS_LLO:   q_word.data = flen_reg[7:0];
            sfb64_pkg::FS_DATA:  q_word.data = data_reg;
            sfb64_pkg::FS_END:   q_word.kind = sfb64_pkg::OP_END;
            default:             q_word.data = 8'h00;
        endcase
    end

    always_comb
    begin
        data_next     = data_reg;
        last_next     = last_reg;
        flen_next     = flen_reg;
        in_frame_next = in_frame_reg;
        if (accept)
        begin
            data_next = data_byte;
            last_next = last;
            if (first)
            begin
                flen_next     = plen_ext + 16'd2;
                in_frame_next = !last;
            end
            else if (last)
            begin
                in_frame_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sfb64_pkg::FS_IDLE;
            in_frame_reg <= 1'b0;
            data_reg     <= 8'h00;
            last_reg     <= 1'b0;
            flen_reg     <= 16'h0000;
        end
        else
        begin
            state_reg    <= state_next;
            in_frame_reg <= in_frame_next;
            data_reg     <= data_next;
            last_reg     <= last_next;
            flen_reg     <= flen_next;
        end
    end

endmodule

// ===== sv/sfb64_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb64_queue
// Short queue of stream operations between the front and back parts.
// ----------------------------------------------------------------------------
module sfb64_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfb64_pkg::op_word_t  wr_word,
    output logic                 full,
    input  logic                 pop,
    output sfb64_pkg::op_word_t  rd_word,
    output logic                 empty
);

    sfb64_pkg::op_word_t          mem_reg [sfb64_pkg::QDEPTH];
    logic [sfb64_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sfb64_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sfb64_pkg::QPTR_W:0]   cnt_reg, cnt_next;

    logic do_push;
    logic do_pop;

    assign full    = (cnt_reg == (sfb64_pkg::QPTR_W + 1)'(sfb64_pkg::QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== sv/sfb64_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb64_back
// Runs the CRC and base64 grouper and sends wire bytes through an output stage.
// ----------------------------------------------------------------------------
module sfb64_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  sfb64_pkg::op_word_t  q_word,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           wire_byte,
    output logic                 frame_end
);

    sfb64_pkg::back_state_t state_reg, state_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] pend_reg, pend_next;
    logic [1:0]  pcnt_reg, pcnt_next;
    logic [31:0] burst_reg, burst_next;
    logic [2:0]  burst_cnt_reg, burst_cnt_next;
    logic        burst_fe_reg, burst_fe_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_end_reg, out_end_next;

    logic        out_free;
    logic        send;
    logic        step;
    logic        load;
    logic [31:0] load_word;
    logic [2:0]  load_cnt;
    logic        load_fe;
    logic        do_raw;
    logic [7:0]  raw_b;
    logic [23:0] grp;

    assign out_free = !out_valid_reg || pop;
    assign send     = (burst_cnt_reg != 3'd0) && out_free;
    assign step     = (burst_cnt_reg == 3'd0) || ((burst_cnt_reg == 3'd1) && out_free);

    assign empty     = !out_valid_reg;
    assign wire_byte = out_byte_reg;
    assign frame_end = out_end_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfb64_pkg::BK_OP:
            begin
                if (step && !q_empty && (q_word.kind == sfb64_pkg::OP_END))
                begin
                    state_next = sfb64_pkg::BK_LO;
                end
            end
            sfb64_pkg::BK_LO:  if (step) state_next = sfb64_pkg::BK_PAD;
            sfb64_pkg::BK_PAD: if (step) state_next = sfb64_pkg::BK_NL;
            sfb64_pkg::BK_NL:  if (step) state_next = sfb64_pkg::BK_OP;
            default:           state_next = sfb64_pkg::BK_OP;
        endcase
    end

    // actions
    always_comb
    begin
        crc_next  = crc_reg;
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        load      = 1'b0;
        load_word = 32'h0;
        load_cnt  = 3'd0;
        load_fe   = 1'b0;
        q_pop     = 1'b0;
        do_raw    = 1'b0;
        raw_b     = 8'h00;
        grp       = 24'h0;
        case (state_reg)
            sfb64_pkg::BK_OP:
            begin
                if (step && !q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_word.kind)
                        sfb64_pkg::OP_START:
                        begin
                            crc_next  = 16'h0000;
                            pend_next = 16'h0000;
                            pcnt_next = 2'd0;
                            load      = 1'b1;
                            load_word = {sfb64_pkg::CH_PRE0, sfb64_pkg::CH_PRE1, 16'h0000};
                            load_cnt  = 3'd2;
                        end
                        sfb64_pkg::OP_RAW:
                        begin
                            crc_next = sfb64_pkg::crc16_byte(crc_reg, q_word.data);
                            do_raw   = 1'b1;
                            raw_b    = q_word.data;
                        end
                        sfb64_pkg::OP_END:
                        begin
                            do_raw = 1'b1;
                            raw_b  = crc_reg[15:8];
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            sfb64_pkg::BK_LO:
            begin
                if (step)
                begin
                    do_raw = 1'b1;
                    raw_b  = crc_reg[7:0];
                end
            end
            sfb64_pkg::BK_PAD:
            begin
                if (step)
                begin
                    if (pcnt_reg == 2'd1)
                    begin
                        grp       = {pend_reg[7:0], 16'h0000};
                        load      = 1'b1;
                        load_word = {sfb64_pkg::b64_char(grp[23:18]),
                                     sfb64_pkg::b64_char(grp[17:12]),
                                     sfb64_pkg::CH_PAD, sfb64_pkg::CH_PAD};
                        load_cnt  = 3'd4;
                    end
                    else if (pcnt_reg == 2'd2)
                    begin
                        grp       = {pend_reg, 8'h00};
                        load      = 1'b1;
                        load_word = {sfb64_pkg::b64_char(grp[23:18]),
                                     sfb64_pkg::b64_char(grp[17:12]),
                                     sfb64_pkg::b64_char(grp[11:6]),
                                     sfb64_pkg::CH_PAD};
                        load_cnt  = 3'd4;
                    end
                    pend_next = 16'h0000;
                    pcnt_next = 2'd0;
                end
            end
            sfb64_pkg::BK_NL:
            begin
                if (step)
                begin
                    crc_next  = 16'h0000;
                    load      = 1'b1;
                    load_word = {sfb64_pkg::CH_NL, 24'h000000};
                    load_cnt  = 3'd1;
                    load_fe   = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase

        // base64 grouper
        if (do_raw)
        begin
            if (pcnt_reg < 2'd2)
            begin
                pend_next = {pend_reg[7:0], raw_b};
                pcnt_next = pcnt_reg + 2'd1;
            end
            else
            begin
                grp       = {pend_reg, raw_b};
                load      = 1'b1;
                load_word = {sfb64_pkg::b64_char(grp[23:18]),
                             sfb64_pkg::b64_char(grp[17:12]),
                             sfb64_pkg::b64_char(grp[11:6]),
                             sfb64_pkg::b64_char(grp[5:0])};
                load_cnt  = 3'd4;
                pend_next = 16'h0000;
                pcnt_next = 2'd0;
            end
        end
    end

    always_comb
    begin
        burst_next     = burst_reg;
        burst_cnt_next = burst_cnt_reg;
        burst_fe_next  = burst_fe_reg;
        if (load)
        begin
            burst_next     = load_word;
            burst_cnt_next = load_cnt;
            burst_fe_next  = load_fe;
        end
        else if (send)
        begin
            burst_next     = {burst_reg[23:0], 8'h00};
            burst_cnt_next = burst_cnt_reg - 3'd1;
        end

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        if (send)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = burst_reg[31:24];
            out_end_next   = burst_fe_reg;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfb64_pkg::BK_OP;
            crc_reg       <= 16'h0000;
            pend_reg      <= 16'h0000;
            pcnt_reg      <= 2'd0;
            burst_reg     <= 32'h0;
            burst_cnt_reg <= 3'd0;
            burst_fe_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            crc_reg       <= crc_next;
            pend_reg      <= pend_next;
            pcnt_reg      <= pcnt_next;
            burst_reg     <= burst_next;
            burst_cnt_reg <= burst_cnt_next;
            burst_fe_reg  <= burst_fe_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_end_reg   <= out_end_next;
        end
    end

endmodule

// ===== sv/serial_frame_base64_crc_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_base64_crc_encoder
// Frames packet bytes as 0x06 0x09, base64 of length, data and CRC-16, newline.
//
//   channel  | handshake     | words
//   ---------+---------------+--------------------------------------------
//   input    | push / full   | data_byte, first, last, packet_length
//   result   | pop / empty   | wire_byte, frame_end
//
// a middle packet byte passes the front and then the back, and every
// third raw byte has the back send four base64 characters, so the
// output port sets the pace. a first byte issues four queue words, a
// last byte one more; the end of frame takes four back steps and sends
// up to nine wire bytes.
// reset clears all state but the queue storage; no clearing pass. a stall
// on pop fills the four word queue, then full rises.
// ----------------------------------------------------------------------------
module serial_frame_base64_crc_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       first,
    input  logic       last,
    input  logic [8:0] packet_length,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] wire_byte,
    output logic       frame_end
);

    logic                 fq_push;
    sfb64_pkg::op_word_t  fq_word;
    logic                 fq_full;
    logic                 bq_pop;
    sfb64_pkg::op_word_t  bq_word;
    logic                 bq_empty;

    sfb64_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .first         (first),
        .last          (last),
        .packet_length (packet_length),
        .q_push        (fq_push),
        .q_word        (fq_word),
        .q_full        (fq_full)
    );

    sfb64_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .wr_word (fq_word),
        .full    (fq_full),
        .pop     (bq_pop),
        .rd_word (bq_word),
        .empty   (bq_empty)
    );

    sfb64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (bq_empty),
        .q_word    (bq_word),
        .q_pop     (bq_pop),
        .empty     (empty),
        .pop       (pop),
        .wire_byte (wire_byte),
        .frame_end (frame_end)
    );

endmodule
